// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: status codes,
// operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int TAG_BITS_DEF = 16;

	localparam int IN_TAG_W = 16;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_NEXT,
		S_INS_CMP,
		S_REM_CAP,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic ins_rd;
		logic ins_shift;
		logic ins_place;
		logic set_full;
		logic set_empty;
		logic rem_rd;
		logic rem_take;
		logic out_load;
	} spq_cmd_t;

	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic k_zero;
		logic fits;
		logic out_free;
	} spq_stat_t;

endpackage

// ===== rtl/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller for the stable priority queue: sequences decode, the backward
// insert shift walk, head removal and the hand-off to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_cmd_t  cmd
);

	spq_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = spq_pkg::S_DECODE;
				end
			end
			spq_pkg::S_DECODE: begin
				if (stat.is_remove) begin
					if (stat.empty) begin
						cmd.set_empty = 1'b1;
						state_d       = spq_pkg::S_RESP;
					end else begin
						cmd.rem_rd = 1'b1;
						state_d    = spq_pkg::S_REM_CAP;
					end
				end else if (stat.full) begin
					cmd.set_full = 1'b1;
					state_d      = spq_pkg::S_RESP;
				end else begin
					state_d = spq_pkg::S_INS_NEXT;
				end
			end
			spq_pkg::S_INS_NEXT: begin
				if (stat.k_zero) begin
					cmd.ins_place = 1'b1;
					state_d       = spq_pkg::S_RESP;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = spq_pkg::S_INS_CMP;
				end
			end
			spq_pkg::S_INS_CMP: begin
				if (stat.fits) begin
					cmd.ins_place = 1'b1;
					state_d       = spq_pkg::S_RESP;
				end else begin
					cmd.ins_shift = 1'b1;
					state_d       = spq_pkg::S_INS_NEXT;
				end
			end
			spq_pkg::S_REM_CAP: begin
				cmd.rem_take = 1'b1;
				state_d      = spq_pkg::S_RESP;
			end
			spq_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/spq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// Datapath for the stable priority queue: circular entry store, head and
// count registers, insert walk pointers, pending result and output register.
// ----------------------------------------------------------------------------
module spq_dp #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           func,
	input  logic [spq_pkg::IN_TAG_W-1:0]   entry_tag,
	input  logic [spq_pkg::PRIO_W-1:0]     entry_priority,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [spq_pkg::STATUS_W-1:0]   status,
	output logic [spq_pkg::IN_TAG_W-1:0]   served_tag,
	output logic [spq_pkg::PRIO_W-1:0]     served_priority,
	output logic [spq_pkg::OCC_W-1:0]      occupancy,
	input  spq_pkg::spq_cmd_t              cmd,
	output spq_pkg::spq_stat_t             stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam int DW = TAG_BITS + spq_pkg::PRIO_W;

	logic [AW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               wr_ptr_q;
	logic [CW-1:0]               k_q;
	logic                        func_q;
	logic [TAG_BITS-1:0]         new_tag_q;
	logic [spq_pkg::PRIO_W-1:0]  new_prio_q;

	spq_pkg::status_code_t       res_status_q;
	logic [TAG_BITS-1:0]         res_tag_q;
	logic [spq_pkg::PRIO_W-1:0]  res_prio_q;

	logic                        out_valid_q;
	logic [spq_pkg::STATUS_W-1:0] out_status_q;
	logic [spq_pkg::IN_TAG_W-1:0] out_tag_q;
	logic [spq_pkg::PRIO_W-1:0]  out_prio_q;
	logic [spq_pkg::OCC_W-1:0]   out_occ_q;

	logic [SW-1:0]               tail_sum;
	logic [AW-1:0]               tail_ptr;
	logic [AW-1:0]               rd_ptr;
	logic [AW-1:0]               head_inc;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [DW-1:0]               ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [DW-1:0]               ram_rdata;
	logic [TAG_BITS-1:0]         rd_tag;
	logic [spq_pkg::PRIO_W-1:0]  rd_prio;

	// physical slot just past the tail of the circular store
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail_ptr = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
		: AW'(tail_sum);
	assign rd_ptr   = (wr_ptr_q == '0) ? AW'(CAPACITY - 1) : AW'(wr_ptr_q - 1'b1);
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : AW'(head_q + 1'b1);

	assign rd_tag  = ram_rdata[DW-1:spq_pkg::PRIO_W];
	assign rd_prio = ram_rdata[spq_pkg::PRIO_W-1:0];

	assign ram_we    = cmd.ins_place | cmd.ins_shift;
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = cmd.ins_place ? {new_tag_q, new_prio_q} : ram_rdata;
	assign ram_re    = cmd.ins_rd | cmd.rem_rd;
	assign ram_raddr = cmd.rem_rd ? head_q : rd_ptr;

	spq_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_place) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (cmd.rem_take) begin
				count_q <= CW'(count_q - 1'b1);
				head_q  <= head_inc;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			new_tag_q  <= TAG_BITS'(entry_tag);
			new_prio_q <= entry_priority;
			wr_ptr_q   <= tail_ptr;
			k_q        <= count_q;
		end
		if (cmd.ins_shift) begin
			wr_ptr_q <= rd_ptr;
			k_q      <= CW'(k_q - 1'b1);
		end
		if (cmd.ins_place) begin
			res_status_q <= spq_pkg::ST_INSERTED;
			res_tag_q    <= '0;
			res_prio_q   <= '0;
		end
		if (cmd.set_full) begin
			res_status_q <= spq_pkg::ST_FULL;
			res_tag_q    <= '0;
			res_prio_q   <= '0;
		end
		if (cmd.set_empty) begin
			res_status_q <= spq_pkg::ST_EMPTY;
			res_tag_q    <= '0;
			res_prio_q   <= '0;
		end
		if (cmd.rem_take) begin
			res_status_q <= spq_pkg::ST_REMOVED;
			res_tag_q    <= rd_tag;
			res_prio_q   <= rd_prio;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_tag_q    <= spq_pkg::IN_TAG_W'(res_tag_q);
			out_prio_q   <= res_prio_q;
			out_occ_q    <= spq_pkg::OCC_W'(count_q);
		end
	end

	assign stat.is_remove = (func_q == spq_pkg::FUNC_REMOVE);
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.k_zero    = (k_q == '0);
	assign stat.fits      = (rd_prio <= new_prio_q);
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign served_tag      = out_tag_q;
	assign served_priority = out_prio_q;
	assign occupancy       = out_occ_q;

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable priority queue held in a circular RAM in service order.
// Operation: remove runs decode, head read and capture, then loads the result; an empty
// remove or full refusal loads it after decode; insert walks back, moving up each entry of greater priority value.
// Flow: one item at a time, next item taken in the cycle after the result loads.
// Reset: asynchronous, clears count, head and output valid; RAM is not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [spq_pkg::IN_TAG_W-1:0] entry_tag,
	input  logic [spq_pkg::PRIO_W-1:0]   entry_priority,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [spq_pkg::STATUS_W-1:0] status,
	output logic [spq_pkg::IN_TAG_W-1:0] served_tag,
	output logic [spq_pkg::PRIO_W-1:0]   served_priority,
	output logic [spq_pkg::OCC_W-1:0]    occupancy
);

	spq_pkg::spq_cmd_t  cmd;
	spq_pkg::spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.func            (func),
		.entry_tag       (entry_tag),
		.entry_priority  (entry_priority),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.served_tag      (served_tag),
		.served_priority (served_priority),
		.occupancy       (occupancy),
		.cmd             (cmd),
		.stat            (stat)
	);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item in progress");

	a_served_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != spq_pkg::ST_REMOVED |-> served_tag == '0 && served_priority == '0)
		else $error("served fields nonzero without a removal");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_FULL |-> occupancy == spq_pkg::OCC_W'(CAPACITY))
		else $error("full refusal with wrong occupancy");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty report with nonzero occupancy");

endmodule
